// ----- hdl/dirty_tile_map_core_macros.svh -----
// ----------------------------------------------------------------------------
// dirty tile map assertion macros
// shared concurrent assertion forms, clocked on clock, held off in reset
// ----------------------------------------------------------------------------
`ifndef DIRTY_TILE_MAP_CORE_MACROS_SVH
`define DIRTY_TILE_MAP_CORE_MACROS_SVH

// same-cycle implication
`define DTM_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dirty tile map assertion failed");

// next-cycle implication
`define DTM_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dirty tile map assertion failed");

`endif

// ----- hdl/dtm_pkg.sv -----
// ----------------------------------------------------------------------------
// dtm_pkg
// types and constants shared by the dirty tile map modules
// ----------------------------------------------------------------------------
package dtm_pkg;

   localparam int MAX_COLS = 32;
   localparam int MAX_ROWS = 32;
   localparam int ROW_AW = 5;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_AW = 1;

   localparam logic [5:0] COLS_RESET = 6'd20;
   localparam logic [5:0] ROWS_RESET = 6'd13;

   localparam logic CSR_MAP_COLS = 1'b0;
   localparam logic CSR_MAP_ROWS = 1'b1;

   localparam logic [2:0] MODE_DIRTY = 3'd0;
   localparam logic [2:0] MODE_CLEAN = 3'd1;
   localparam logic [2:0] MODE_MASK = 3'd2;
   localparam logic [2:0] MODE_CLEAR = 3'd3;
   localparam logic [2:0] MODE_RESTORE = 3'd4;

   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_SET = 3'd1,
      OP_CLR = 3'd2,
      OP_MASK = 3'd3,
      OP_CLEAR = 3'd4,
      OP_RESTORE = 3'd5
   } op_type;

   typedef struct packed {
      op_type op;
      logic bounds_err;
      logic set_dirty;
      logic [ROW_AW-1:0] y1;
      logic [ROW_AW-1:0] y2;
      logic [ROW_AW-1:0] srow;
      logic [MAX_COLS-1:0] span;
      logic [MAX_COLS-1:0] cmask;
      logic [5:0] cols;
      logic [5:0] rows;
   } cmd_type;

   function automatic logic [5:0] clamp_dim(input logic [5:0] v);
      logic [5:0] r;
      r = v;
      if (v == 6'd0) r = 6'd1;
      else if (v > 6'd32) r = 6'd32;
      return r;
   endfunction

endpackage

// ----- hdl/dtm_front.sv -----
// ----------------------------------------------------------------------------
// dtm_front
// config registers and command decode: tile bounds, span and column masks
// ----------------------------------------------------------------------------
module dtm_front (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic csr_addr,
   input  logic [5:0] csr_wdata,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [47:0] req_tdata,
   input  logic [2:0] req_tuser,
   output logic push,
   output dtm_pkg::cmd_type push_cmd,
   input  logic full
);

   logic [5:0] cols_ff, cols_in, rows_ff, rows_in;
   logic [5:0] cols, rows;
   logic [8:0] left, top;
   logic [9:0] wid, hgt;
   logic [4:0] srow;
   logic [10:0] xsum, ysum;
   logic [6:0] x2, y2;
   logic [4:0] x1, y1;
   logic rect_err, clip;
   dtm_pkg::cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= dtm_pkg::COLS_RESET;
         rows_ff <= dtm_pkg::ROWS_RESET;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_we) begin
         case (csr_addr)
            dtm_pkg::CSR_MAP_COLS: cols_in = csr_wdata;
            dtm_pkg::CSR_MAP_ROWS: rows_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign left = req_tdata[8:0];
   assign top = req_tdata[17:9];
   assign wid = req_tdata[27:18];
   assign hgt = req_tdata[37:28];
   assign srow = req_tdata[42:38];

   assign cols = dtm_pkg::clamp_dim(cols_ff);
   assign rows = dtm_pkg::clamp_dim(rows_ff);

   assign xsum = {2'b00, left} + {1'b0, wid} - 11'd1;
   assign ysum = {2'b00, top} + {1'b0, hgt} - 11'd1;
   assign x1 = left[8:4];
   assign y1 = top[8:4];
   assign x2 = xsum[10:4];
   assign y2 = ysum[10:4];
   assign rect_err = (wid == 10'd0) || (hgt == 10'd0) ||
                     (x2 >= {1'b0, cols}) || (y2 >= {1'b0, rows});
   assign clip = (y1 != 5'd0) || ({1'b0, y2} + 8'd1 < {2'b00, rows}) ||
                 (x1 != 5'd0) || ({1'b0, x2} + 8'd1 < {2'b00, cols});

   always_comb begin
      cmd = '0;
      cmd.op = dtm_pkg::OP_NONE;
      cmd.cols = cols;
      cmd.rows = rows;
      cmd.srow = srow;
      cmd.y1 = y1;
      cmd.y2 = y2[4:0];
      for (int c = 0; c < dtm_pkg::MAX_COLS; c++) begin
         cmd.span[c] = (6'(c) >= {1'b0, x1}) && (7'(c) <= x2);
         cmd.cmask[c] = 6'(c) < cols;
      end
      case (req_tuser)
         dtm_pkg::MODE_DIRTY, dtm_pkg::MODE_CLEAN, dtm_pkg::MODE_MASK: begin
            if (rect_err) begin
               cmd.bounds_err = 1'b1;
            end else begin
               case (req_tuser)
                  dtm_pkg::MODE_DIRTY: cmd.op = dtm_pkg::OP_SET;
                  dtm_pkg::MODE_CLEAN: cmd.op = dtm_pkg::OP_CLR;
                  default: cmd.op = dtm_pkg::OP_MASK;
               endcase
               cmd.set_dirty = (req_tuser != dtm_pkg::MODE_MASK) || clip;
            end
         end
         dtm_pkg::MODE_CLEAR: cmd.op = dtm_pkg::OP_CLEAR;
         dtm_pkg::MODE_RESTORE: begin
            if ({1'b0, srow} >= rows) cmd.bounds_err = 1'b1;
            else cmd.op = dtm_pkg::OP_RESTORE;
         end
         default: ;
      endcase
   end

   assign req_tready = !full;
   assign push = req_tvalid && !full;
   assign push_cmd = cmd;

endmodule

// ----- hdl/dtm_fifo.sv -----
// ----------------------------------------------------------------------------
// dtm_fifo
// short command queue between decode and the map sequencer
// ----------------------------------------------------------------------------
module dtm_fifo (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  dtm_pkg::cmd_type push_cmd,
   output logic full,
   input  logic pop,
   output dtm_pkg::cmd_type pop_cmd,
   output logic empty
);

   dtm_pkg::cmd_type mem_ff [dtm_pkg::FIFO_DEPTH];
   logic [dtm_pkg::FIFO_AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [dtm_pkg::FIFO_AW:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_cmd;
   end

   always_comb begin
      wp_in = push ? wp_ff + 1'b1 : wp_ff;
      rp_in = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
   end

   assign full = cnt_ff == (dtm_pkg::FIFO_AW+1)'(dtm_pkg::FIFO_DEPTH);
   assign empty = cnt_ff == '0;
   assign pop_cmd = mem_ff[rp_ff];

endmodule

// ----- hdl/dtm_back.sv -----
// ----------------------------------------------------------------------------
// dtm_back
// tile map storage and sequencer: row walks, byte restore, result register
// ----------------------------------------------------------------------------
`include "dirty_tile_map_core_macros.svh"

module dtm_back (
   input  logic clock,
   input  logic reset,
   input  logic empty,
   input  dtm_pkg::cmd_type pop_cmd,
   output logic pop,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [39:0] rsp_tdata,  // out_left, out_top, out_width, out_height, map_dirty, bounds_error
   output logic rsp_tlast,
   output logic rsp_tuser          // has_rect
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MARK = 6'b000010,
      ST_SBYTE = 6'b000100,
      ST_SCLR = 6'b001000,
      ST_SRUN = 6'b010000,
      ST_CLOSE = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   dtm_pkg::cmd_type cmd_ff, cmd_in;
   logic [dtm_pkg::MAX_COLS-1:0] tile_ff [dtm_pkg::MAX_ROWS];
   logic [dtm_pkg::MAX_COLS-1:0] tile_in [dtm_pkg::MAX_ROWS];
   logic [4:0] row_ff, row_in;
   logic [1:0] byte_ff, byte_in;
   logic [7:0] val_ff, val_in;
   logic [5:0] h_ff, h_in;
   logic [2:0] bit_ff, bit_in, start_ff, start_in;
   logic in_run_ff, in_run_in, dirty_ff, dirty_in;
   logic out_valid_ff, out_valid_in;
   logic [39:0] out_data_ff, out_data_in;
   logic out_last_ff, out_last_in, out_has_ff, out_has_in;

   logic [31:0] rd_data, rd_masked, bm, row_new;
   logic [7:0] rd_byte;
   logic [2:0] nxt_byte, s_cur;
   logic byte_last, row_last, in_rect, can_put, cur_bit, nxt_bit, run_end;
   logic [3:0] run_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dirty_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int r = 0; r < dtm_pkg::MAX_ROWS; r++) tile_ff[r] <= '0;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
         out_valid_ff <= out_valid_in;
         tile_ff <= tile_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      row_ff <= row_in;
      byte_ff <= byte_in;
      val_ff <= val_in;
      h_ff <= h_in;
      bit_ff <= bit_in;
      start_ff <= start_in;
      in_run_ff <= in_run_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_has_ff <= out_has_in;
   end

   assign rd_data = tile_ff[row_ff];
   assign rd_masked = rd_data & cmd_ff.cmask;
   assign rd_byte = rd_masked[{byte_ff, 3'b000} +: 8];
   assign bm = cmd_ff.cmask & (32'h0000_00ff << {byte_ff, 3'b000});
   assign nxt_byte = {1'b0, byte_ff} + 3'd1;
   assign byte_last = {nxt_byte, 3'b000} >= cmd_ff.cols;
   assign row_last = ({1'b0, row_ff} + 6'd1) >= cmd_ff.rows;
   assign in_rect = (row_ff >= cmd_ff.y1) && (row_ff <= cmd_ff.y2);
   assign can_put = !out_valid_ff || rsp_tready;
   assign cur_bit = val_ff[bit_ff];
   assign nxt_bit = (bit_ff == 3'd7) ? 1'b0 : val_ff[bit_ff + 3'd1];
   assign run_end = cur_bit && !nxt_bit;
   assign s_cur = in_run_ff ? start_ff : bit_ff;
   assign run_len = {1'b0, bit_ff} - {1'b0, s_cur} + 4'd1;

   always_comb begin
      row_new = rd_data;
      case (cmd_ff.op)
         dtm_pkg::OP_SET: if (in_rect) row_new = rd_data | cmd_ff.span;
         dtm_pkg::OP_CLR: if (in_rect) row_new = rd_data & ~cmd_ff.span;
         dtm_pkg::OP_MASK: begin
            if (in_rect) row_new = rd_data & (cmd_ff.span | ~cmd_ff.cmask);
            else row_new = rd_data & ~cmd_ff.cmask;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      tile_in = tile_ff;
      row_in = row_ff;
      byte_in = byte_ff;
      val_in = val_ff;
      h_in = h_ff;
      bit_in = bit_ff;
      start_in = start_ff;
      in_run_in = in_run_ff;
      dirty_in = dirty_ff;
      pop = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      out_has_in = out_has_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               cmd_in = pop_cmd;
               row_in = '0;
               byte_in = '0;
               case (pop_cmd.op)
                  dtm_pkg::OP_SET, dtm_pkg::OP_CLR, dtm_pkg::OP_MASK: begin
                     if (pop_cmd.set_dirty) dirty_in = 1'b1;
                     state_in = ST_MARK;
                  end
                  dtm_pkg::OP_CLEAR: begin
                     for (int r = 0; r < dtm_pkg::MAX_ROWS; r++) tile_in[r] = '0;
                     dirty_in = 1'b0;
                     state_in = ST_CLOSE;
                  end
                  dtm_pkg::OP_RESTORE: begin
                     row_in = pop_cmd.srow;
                     if (pop_cmd.srow == '0) dirty_in = 1'b0;
                     state_in = ST_SBYTE;
                  end
                  default: state_in = ST_CLOSE;
               endcase
            end
         end
         ST_MARK: begin
            tile_in[row_ff] = row_new;
            if (row_last) state_in = ST_CLOSE;
            else row_in = row_ff + 5'd1;
         end
         ST_SBYTE: begin
            val_in = rd_byte;
            h_in = '0;
            if (rd_byte != 8'd0) state_in = ST_SCLR;
            else if (byte_last) state_in = ST_CLOSE;
            else byte_in = nxt_byte[1:0];
         end
         ST_SCLR: begin
            if (rd_byte == val_ff) begin
               tile_in[row_ff] = rd_data & ~bm;
               h_in = h_ff + 6'd1;
            end
            if (rd_byte != val_ff || row_last) begin
               row_in = cmd_ff.srow;
               bit_in = '0;
               in_run_in = 1'b0;
               state_in = ST_SRUN;
            end else begin
               row_in = row_ff + 5'd1;
            end
         end
         ST_SRUN: begin
            if (!run_end || can_put) begin
               if (run_end) begin
                  out_valid_in = 1'b1;
                  out_data_in = {1'b0, dirty_ff, {h_ff, 4'b0000},
                                 {2'b00, run_len, 4'b0000},
                                 {cmd_ff.srow, 4'b0000}, {byte_ff, s_cur, 4'b0000}};
                  out_last_in = 1'b0;
                  out_has_in = 1'b1;
               end
               start_in = s_cur;
               in_run_in = cur_bit && !run_end;
               if (bit_ff == 3'd7) begin
                  if (byte_last) begin
                     state_in = ST_CLOSE;
                  end else begin
                     byte_in = nxt_byte[1:0];
                     state_in = ST_SBYTE;
                  end
               end else begin
                  bit_in = bit_ff + 3'd1;
               end
            end
         end
         ST_CLOSE: begin
            if (can_put) begin
               out_valid_in = 1'b1;
               out_data_in = {cmd_ff.bounds_err, dirty_ff, 38'd0};
               out_last_in = 1'b1;
               out_has_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tlast = out_last_ff;
   assign rsp_tuser = out_has_ff;

   `DTM_ASSERT_IMP(a_rect_no_err, out_valid_ff && out_has_ff, !out_data_ff[39] && !out_last_ff)
   `DTM_ASSERT_NXT(a_clear_dirty, pop && pop_cmd.op == dtm_pkg::OP_CLEAR, !dirty_ff)
   `DTM_ASSERT_IMP(a_height_rows, state_ff == ST_SCLR, h_ff < cmd_ff.rows)

endmodule

// ----- hdl/dirty_tile_map_core.sv -----
// mark commands walk every row of the map; clear and rejected commands go straight to the result
// restore reads the row byte by byte, and for each nonzero byte compares rows from scan_row on,
// the first differing row included, then walks the byte bit by bit for runs
// the sequencer over the single-ported tile row read sets the rate, one command at a time
// a two-entry command queue lets the next beat be taken while a result waits
// synchronous reset clears the map, the dirty flag and the queue; map_cols 20, map_rows 13
// ----------------------------------------------------------------------------
// dirty_tile_map_core
// dirty tile bitmap with mark, mask, clear and restore-row commands
// ----------------------------------------------------------------------------
module dirty_tile_map_core (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic csr_addr,
   input  logic [5:0] csr_wdata,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [47:0] req_tdata,   // rect_left, rect_top, rect_width, rect_height, scan_row
   input  logic [2:0] req_tuser,    // mode
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [39:0] rsp_tdata,   // out_left, out_top, out_width, out_height, map_dirty, bounds_error
   output logic rsp_tlast,
   output logic rsp_tuser           // has_rect
);

   logic push, full, pop, empty;
   dtm_pkg::cmd_type push_cmd, pop_cmd;

   dtm_front u_front (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .push(push), .push_cmd(push_cmd), .full(full)
   );

   dtm_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(push), .push_cmd(push_cmd), .full(full),
      .pop(pop), .pop_cmd(pop_cmd), .empty(empty)
   );

   dtm_back u_back (
      .clock(clock), .reset(reset),
      .empty(empty), .pop_cmd(pop_cmd), .pop(pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

endmodule
